// ===== src/kfc_pkg.sv =====
// Shared types and constants for the keypad calculator core.
// No dependencies; kfc_decode and the core in src import this package.
package kfc_pkg;

  // Port field widths, fixed by the interface
  localparam int BTN_W     = 12;
  localparam int FIELD_W   = 16;
  localparam int OP_W      = 4;
  localparam int RES_W     = 23;

  // Button layout
  localparam int DIGIT_KEYS = 10;  // bits 0..9
  localparam int SCI_KEYS   = 9;   // bits 0..8 become operators in scientific mode
  localparam int BTN_EQ     = 10;
  localparam int MODE_KEY   = 11;

  localparam int DEC_BASE   = 10;
  localparam int SCALE      = 100;  // result reported in hundredths

  // Operator codes
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL    = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV    = 4'd4;
  localparam logic [OP_W-1:0] OP_EQUALS = 4'd10;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_DIGIT,
    KIND_OP,
    KIND_MODE,
    KIND_EQ
  } key_kind_t;

  typedef struct packed {
    key_kind_t       kind;
    logic [OP_W-1:0] val;   // digit value or operator code
  } key_t;

endpackage

// ===== src/kfc_decode.sv =====
// Priority decode of the press mask into a key class and value.
// Depends on kfc_pkg.
module kfc_decode
  import kfc_pkg::*;
(
  input  logic [BTN_W-1:0] buttons,
  input  logic             sci,
  output key_t             key
);

  // Later assignments override earlier ones: equals lowest, then mode,
  // then digit keys with the lowest bit winning.
  always_comb begin
    key.kind = KIND_NONE;
    key.val  = OP_NONE;
    if (buttons[BTN_EQ]) begin
      key.kind = KIND_EQ;
      key.val  = OP_EQUALS;
    end
    if (buttons[MODE_KEY]) begin
      key.kind = KIND_MODE;
      key.val  = OP_NONE;
    end
    for (int k = DIGIT_KEYS - 1; k >= 0; k--) begin
      if (buttons[k]) begin
        if (sci && (k < SCI_KEYS)) begin
          key.kind = KIND_OP;
          key.val  = OP_W'(k + 1);
        end else begin
          key.kind = KIND_DIGIT;
          key.val  = OP_W'(k);
        end
      end
    end
  end

endmodule

// ===== src/kfc_mul.sv =====
// Shift-add multiply-accumulate, one multiplier bit per cycle: p = a*b + c mod 2^W.
// Depends on nothing beyond its parameters.
module kfc_mul #(
  parameter int W  = 24,
  parameter int MB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  a,
  input  logic [MB-1:0] b,
  input  logic [W-1:0]  c,
  output logic          done,
  output logic [W-1:0]  p
);

  localparam int CW = $clog2(MB + 1);

  logic [W-1:0]  a_r, a_nxt;
  logic [MB-1:0] b_r, b_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = c;
      cnt_nxt  = CW'(MB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (b_r[0] ? a_r : '0);
      a_nxt   = {a_r[W-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[MB-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ===== src/kfc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// Depends on nothing beyond its parameter.
module kfc_div #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem_r, q_r[W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so W bits hold it
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== src/keypad_four_function_calculator_core.sv =====
// Keypad calculator core: one press word in, one status/result word out.
// Keys with no arithmetic go straight to ST_DONE; a digit or equals on add/sub runs one
// multiply, equals on multiply runs two multiplies, equals on divide a multiply then a divide.
// One word in flight; the next word is taken once the result is loaded into the output
// register (in_stall is high from acceptance until the result is loaded).
// Synchronous active-low reset: phase 0, both operands 0, no operator, basic mode.
module keypad_four_function_calculator_core
  import kfc_pkg::*;
#(
  parameter int OPERAND_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // press channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BTN_W-1:0]          in_buttons_pressed,
  // status/result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_phase,
  output logic signed [FIELD_W-1:0] out_first_operand,
  output logic signed [FIELD_W-1:0] out_second_operand,
  output logic [OP_W-1:0]           out_operator_code,
  output logic                      out_scientific_mode,
  output logic                      out_result_valid,
  output logic signed [RES_W-1:0]   out_result_hundredths
);

  localparam int N   = OPERAND_BITS;
  // Datapath width: holds 2*|a|*100 + |b| for the rounded divide, and the
  // 23-bit scaled result.
  localparam int WW  = (N + 8 > RES_W) ? N + 8 : RES_W;
  localparam int EXT = WW - N;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // What the pending multiply is for
  typedef enum logic [1:0] {
    JOB_DIGIT,   // operand*10 + digit
    JOB_PROD,    // a*b, then scale
    JOB_SCALE,   // x*100 -> result
    JOB_NUM      // |a|*100, then divide
  } job_t;

  // Architectural state
  state_t            state_r, state_nxt;
  logic              phase_r, phase_nxt;
  logic [N-1:0]      first_r, first_nxt;
  logic [N-1:0]      second_r, second_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic              sci_r, sci_nxt;

  // Per-word working registers
  job_t              job_r, job_nxt;
  logic              neg_r, neg_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [RES_W-1:0]  res_r, res_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_phase_r, out_phase_nxt;
  logic [FIELD_W-1:0] out_first_r, out_first_nxt;
  logic [FIELD_W-1:0] out_second_r, out_second_nxt;
  logic [OP_W-1:0]   out_op_r, out_op_nxt;
  logic              out_sci_r, out_sci_nxt;
  logic              out_rvalid_r, out_rvalid_nxt;
  logic [RES_W-1:0]  out_res_r, out_res_nxt;

  key_t              key;

  logic              mul_start;
  logic [WW-1:0]     mul_a, mul_c, mul_p;
  logic [N-1:0]      mul_b;
  logic              mul_done;

  logic              div_start;
  logic [WW-1:0]     div_dividend, div_divisor, div_q;
  logic              div_done;

  // Operand helpers
  logic [N-1:0]      op_sum, op_diff, a_abs, b_abs, prod_lo;
  logic [WW-1:0]     q_neg;
  logic [N+FIELD_W-1:0] first_wide, second_wide;
  logic              out_load;

  assign op_sum   = first_r + second_r;
  assign op_diff  = first_r - second_r;
  assign a_abs    = first_r[N-1] ? ('0 - first_r) : first_r;
  assign b_abs    = second_r[N-1] ? ('0 - second_r) : second_r;
  assign prod_lo  = mul_p[N-1:0];
  assign q_neg    = '0 - div_q;
  // Operands reported zero-extended or truncated to the 16-bit field
  assign first_wide  = {{FIELD_W{1'b0}}, first_r};
  assign second_wide = {{FIELD_W{1'b0}}, second_r};

  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  kfc_decode u_decode (
    .buttons (in_buttons_pressed),
    .sci     (sci_r),
    .key     (key)
  );

  kfc_mul #(
    .W  (WW),
    .MB (N)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .c     (mul_c),
    .done  (mul_done),
    .p     (mul_p)
  );

  kfc_div #(
    .W (WW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    op_nxt         = op_r;
    sci_nxt        = sci_r;
    job_nxt        = job_r;
    neg_nxt        = neg_r;
    rvalid_nxt     = rvalid_r;
    res_nxt        = res_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_phase_nxt  = out_phase_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_op_nxt     = out_op_r;
    out_sci_nxt    = out_sci_r;
    out_rvalid_nxt = out_rvalid_r;
    out_res_nxt    = out_res_r;

    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    mul_c          = '0;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt    = '0;
          rvalid_nxt = 1'b0;
          state_nxt  = ST_DONE;
          unique case (key.kind)
            KIND_NONE: begin
            end
            KIND_MODE: begin
              sci_nxt = ~sci_r;
            end
            KIND_DIGIT: begin
              mul_start = 1'b1;
              mul_a     = {{EXT{1'b0}}, (phase_r ? second_r : first_r)};
              mul_b     = N'(DEC_BASE);
              mul_c     = {{(WW-OP_W){1'b0}}, key.val};
              job_nxt   = JOB_DIGIT;
              state_nxt = ST_MUL;
            end
            KIND_OP, KIND_EQ: begin
              if (!phase_r) begin
                // any operator key, equals included, latches and moves on
                op_nxt    = key.val;
                phase_nxt = 1'b1;
              end else if (key.kind == KIND_EQ) begin
                rvalid_nxt = 1'b1;
                if (op_r == OP_ADD || op_r == OP_SUB) begin
                  mul_start = 1'b1;
                  mul_a     = (op_r == OP_ADD) ? {{EXT{op_sum[N-1]}}, op_sum}
                                               : {{EXT{op_diff[N-1]}}, op_diff};
                  mul_b     = N'(SCALE);
                  job_nxt   = JOB_SCALE;
                  state_nxt = ST_MUL;
                end else if (op_r == OP_MUL) begin
                  mul_start = 1'b1;
                  mul_a     = {{EXT{1'b0}}, first_r};
                  mul_b     = second_r;
                  job_nxt   = JOB_PROD;
                  state_nxt = ST_MUL;
                end else if (op_r == OP_DIV && second_r != '0) begin
                  mul_start = 1'b1;
                  mul_a     = {{EXT{1'b0}}, a_abs};
                  mul_b     = N'(SCALE);
                  neg_nxt   = first_r[N-1] ^ second_r[N-1];
                  job_nxt   = JOB_NUM;
                  state_nxt = ST_MUL;
                end
                // divide by zero and scientific ops report zero
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          unique case (job_r)
            JOB_DIGIT: begin
              if (phase_r) begin
                second_nxt = prod_lo;
              end else begin
                first_nxt = prod_lo;
              end
              state_nxt = ST_DONE;
            end
            JOB_PROD: begin
              // wrap the product to N bits, then scale
              mul_start = 1'b1;
              mul_a     = {{EXT{prod_lo[N-1]}}, prod_lo};
              mul_b     = N'(SCALE);
              job_nxt   = JOB_SCALE;
            end
            JOB_SCALE: begin
              res_nxt   = mul_p[RES_W-1:0];
              state_nxt = ST_DONE;
            end
            JOB_NUM: begin
              // round half away: (2n + d) / (2d) on magnitudes
              div_start    = 1'b1;
              div_dividend = {mul_p[WW-2:0], 1'b0} + {{EXT{1'b0}}, b_abs};
              div_divisor  = {{(EXT-1){1'b0}}, b_abs, 1'b0};
              state_nxt    = ST_DIV;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          res_nxt   = neg_r ? q_neg[RES_W-1:0] : div_q[RES_W-1:0];
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          // equals clears the operands and goes back to the first one
          out_valid_nxt  = 1'b1;
          out_phase_nxt  = rvalid_r ? 1'b0 : phase_r;
          out_first_nxt  = rvalid_r ? '0 : first_wide[FIELD_W-1:0];
          out_second_nxt = rvalid_r ? '0 : second_wide[FIELD_W-1:0];
          out_op_nxt     = op_r;
          out_sci_nxt    = sci_r;
          out_rvalid_nxt = rvalid_r;
          out_res_nxt    = res_r;
          if (rvalid_r) begin
            first_nxt  = '0;
            second_nxt = '0;
            phase_nxt  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      first_r     <= '0;
      second_r    <= '0;
      op_r        <= OP_NONE;
      sci_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      op_r        <= op_nxt;
      sci_r       <= sci_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    neg_r        <= neg_nxt;
    rvalid_r     <= rvalid_nxt;
    res_r        <= res_nxt;
    out_phase_r  <= out_phase_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_op_r     <= out_op_nxt;
    out_sci_r    <= out_sci_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_res_r    <= out_res_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_phase             = out_phase_r;
  assign out_first_operand     = out_first_r;
  assign out_second_operand    = out_second_r;
  assign out_operator_code     = out_op_r;
  assign out_scientific_mode   = out_sci_r;
  assign out_result_valid      = out_rvalid_r;
  assign out_result_hundredths = out_res_r;

endmodule

// ===== tb/kfc_press_checker.sv =====
// Checker for the keypad calculator core: predicts the status word for every accepted
// press word and compares it against the result channel. Depends on kfc_pkg only.
module kfc_press_checker
  import kfc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [BTN_W-1:0]          in_buttons_pressed,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_phase,
  input  logic signed [FIELD_W-1:0] out_first_operand,
  input  logic signed [FIELD_W-1:0] out_second_operand,
  input  logic [OP_W-1:0]           out_operator_code,
  input  logic                      out_scientific_mode,
  input  logic                      out_result_valid,
  input  logic signed [RES_W-1:0]   out_result_hundredths,
  output int                        mismatch_count,
  output int                        words_pending,
  output int                        words_checked,
  output int                        evaluations
);

  typedef struct packed {
    logic                      phase;
    logic signed [FIELD_W-1:0] first;
    logic signed [FIELD_W-1:0] second;
    logic [OP_W-1:0]           op;
    logic                      sci;
    logic                      rvalid;
    logic [RES_W-1:0]          res;
  } status_word_t;

  // calculator state as this checker sees it
  logic                      calc_phase;
  logic signed [FIELD_W-1:0] calc_first;
  logic signed [FIELD_W-1:0] calc_second;
  logic [OP_W-1:0]           calc_op;
  logic                      calc_sci;

  status_word_t expected_status[$];
  status_word_t got;
  status_word_t want;
  int errors = 0;
  int checked = 0;
  int evals = 0;

  // lowest pressed key 0..9 wins, then mode, then equals
  function automatic key_t decode_press(input logic [BTN_W-1:0] m, input logic sci);
    key_t k;
    k.kind = KIND_NONE;
    k.val  = OP_NONE;
    for (int b = DIGIT_KEYS - 1; b >= 0; b--) begin
      if (m[b]) begin
        if (sci && b < SCI_KEYS) begin
          k.kind = KIND_OP;
          k.val  = OP_W'(b + 1);
        end else begin
          k.kind = KIND_DIGIT;
          k.val  = OP_W'(b);
        end
      end
    end
    if (k.kind == KIND_NONE) begin
      if (m[MODE_KEY]) begin
        k.kind = KIND_MODE;
      end else if (m[BTN_EQ]) begin
        k.kind = KIND_EQ;
        k.val  = OP_EQUALS;
      end
    end
    return k;
  endfunction

  function automatic logic [RES_W-1:0] hundredths_of(input logic [OP_W-1:0] op,
                                                     input logic signed [FIELD_W-1:0] a,
                                                     input logic signed [FIELD_W-1:0] b);
    logic signed [FIELD_W-1:0] wrapped;
    longint na, nb, num, den, q;
    logic neg;
    q = 0;
    case (op)
      OP_ADD: begin
        wrapped = a + b;
        q = longint'(wrapped) * SCALE;
      end
      OP_SUB: begin
        wrapped = a - b;
        q = longint'(wrapped) * SCALE;
      end
      OP_MUL: begin
        wrapped = a * b;
        q = longint'(wrapped) * SCALE;
      end
      OP_DIV: begin
        if (b != 0) begin
          na  = a;
          nb  = b;
          neg = (na < 0) != (nb < 0);
          num = (na < 0 ? -na : na) * SCALE;
          den = (nb < 0 ? -nb : nb);
          // half away from zero on the magnitude
          q = (2 * num + den) / (2 * den);
          if (neg) q = -q;
        end
      end
      default: q = 0;
    endcase
    return q[RES_W-1:0];
  endfunction

  function automatic status_word_t advance_calculator(input logic [BTN_W-1:0] m);
    key_t k;
    status_word_t w;
    k = decode_press(m, calc_sci);
    w.rvalid = 1'b0;
    w.res    = '0;
    case (k.kind)
      KIND_NONE: ;
      KIND_MODE: calc_sci = ~calc_sci;
      default: begin
        if (!calc_phase) begin
          if (k.kind == KIND_DIGIT) begin
            calc_first = calc_first * DEC_BASE + k.val;
          end else begin
            calc_op    = k.val;
            calc_phase = 1'b1;
          end
        end else if (k.kind == KIND_DIGIT) begin
          calc_second = calc_second * DEC_BASE + k.val;
        end else if (k.kind == KIND_EQ) begin
          w.res       = hundredths_of(calc_op, calc_first, calc_second);
          w.rvalid    = 1'b1;
          calc_first  = '0;
          calc_second = '0;
          calc_phase  = 1'b0;
        end
      end
    endcase
    w.phase  = calc_phase;
    w.first  = calc_first;
    w.second = calc_second;
    w.op     = calc_op;
    w.sci    = calc_sci;
    return w;
  endfunction

  task automatic check_field(input string what, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      calc_phase  = 1'b0;
      calc_first  = '0;
      calc_second = '0;
      calc_op     = OP_NONE;
      calc_sci    = 1'b0;
      expected_status.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_phase, out_first_operand, out_second_operand, out_operator_code,
               out_scientific_mode, out_result_valid, out_result_hundredths};
        if (expected_status.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: status word %h arrived with nothing pending", $realtime, got);
          end
        end else begin
          want = expected_status.pop_front();
          checked++;
          if (got.rvalid) evals++;
          check_field("phase", want.phase, got.phase);
          check_field("first_operand", want.first, got.first);
          check_field("second_operand", want.second, got.second);
          check_field("operator_code", want.op, got.op);
          check_field("scientific_mode", want.sci, got.sci);
          check_field("result_valid", want.rvalid, got.rvalid);
          check_field("result_hundredths", want.res, got.res);
        end
      end
      if (in_valid && !in_stall) begin
        expected_status.push_back(advance_calculator(in_buttons_pressed));
      end
    end
    mismatch_count <= errors;
    words_pending  <= expected_status.size();
    words_checked  <= checked;
    evaluations    <= evals;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the keypad calculator testbench: clock, reset, press stimulus and result-side
// stalls around keypad_four_function_calculator_core, with kfc_press_checker beside it.
// Depends on kfc_pkg, the core and tb/kfc_press_checker.sv.
module testbench;
  import kfc_pkg::*;

  localparam int DIRECTED_PRESSES = 25;
  localparam int RANDOM_PRESSES   = 625;
  // slowest press is a divide; leave plenty of margin
  localparam int DRAIN_CYCLES     = 200;
  localparam int RUN_LIMIT        = 3_200_000;  // hard stop time; the clock period is 8

  localparam logic [BTN_W-1:0] EQ_PRESS   = BTN_W'(1) << BTN_EQ;
  localparam logic [BTN_W-1:0] MODE_PRESS = BTN_W'(1) << MODE_KEY;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [BTN_W-1:0]          in_buttons_pressed;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_phase;
  logic signed [FIELD_W-1:0] out_first_operand;
  logic signed [FIELD_W-1:0] out_second_operand;
  logic [OP_W-1:0]           out_operator_code;
  logic                      out_scientific_mode;
  logic                      out_result_valid;
  logic signed [RES_W-1:0]   out_result_hundredths;

  int mismatch_count;
  int words_pending;
  int words_checked;
  int evaluations;

  // stimulus-side bookkeeping
  int   presses_sent = 0;
  int   burst_left   = 0;
  // shadow of the mode flag and entry phase, only used to shape well-formed sequences
  logic shadow_sci   = 1'b0;
  logic shadow_phase = 1'b0;

  keypad_four_function_calculator_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_buttons_pressed    (in_buttons_pressed),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_phase             (out_phase),
    .out_first_operand     (out_first_operand),
    .out_second_operand    (out_second_operand),
    .out_operator_code     (out_operator_code),
    .out_scientific_mode   (out_scientific_mode),
    .out_result_valid      (out_result_valid),
    .out_result_hundredths (out_result_hundredths)
  );

  kfc_press_checker press_watch (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_buttons_pressed    (in_buttons_pressed),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_phase             (out_phase),
    .out_first_operand     (out_first_operand),
    .out_second_operand    (out_second_operand),
    .out_operator_code     (out_operator_code),
    .out_scientific_mode   (out_scientific_mode),
    .out_result_valid      (out_result_valid),
    .out_result_hundredths (out_result_hundredths),
    .mismatch_count        (mismatch_count),
    .words_pending         (words_pending),
    .words_checked         (words_checked),
    .evaluations           (evaluations)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #RUN_LIMIT;
    $display("testbench failed");
    $finish;
  end

  // Result-side stalls: segments of random length, each with its own stall density
  // (none, light, medium, heavy). Twice in the run the receiver holds off for a long
  // stretch so the single in-flight word backs up and in_stall rises.
  initial begin
    int seg_left;
    int stall_pct;
    int cycle;
    int hold_left;
    seg_left  = 0;
    stall_pct = 0;
    cycle     = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle == 6000 || cycle == 20000) hold_left = 300;
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic logic [BTN_W-1:0] bit_of(input int b);
    return BTN_W'(1) << b;
  endfunction

  // One key bit plus, half the time, random lower-priority bits above it.
  // Noise above the winning key never changes what the press decodes to.
  function automatic logic [BTN_W-1:0] key_press(input int b);
    logic [BTN_W-1:0] noise;
    noise = BTN_W'($urandom);
    noise = noise & ~BTN_W'((2 << b) - 1);
    if ($urandom_range(0, 1) == 0) noise = '0;
    return bit_of(b) | noise;
  endfunction

  // Offer one press word and hold it until accepted. Bursts of back-to-back words
  // alternate with idle gaps; now and then a long burst runs with no idling at all.
  task automatic send_press(input logic [BTN_W-1:0] m);
    int low;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = 40;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 50)) @(posedge clk);
        burst_left = $urandom_range(1, 6);
      end
    end
    in_valid           <= 1'b1;
    in_buttons_pressed <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    presses_sent++;
    // keep the shadow in step: an operator key in phase 0 opens phase 1,
    // mode toggles the flag, equals flips the phase either way
    low = -1;
    for (int b = DIGIT_KEYS - 1; b >= 0; b--) begin
      if (m[b]) low = b;
    end
    if (low >= 0) begin
      if (shadow_sci && low < SCI_KEYS && !shadow_phase) shadow_phase = 1'b1;
    end else if (m[MODE_KEY]) begin
      shadow_sci = ~shadow_sci;
    end else if (m[BTN_EQ]) begin
      shadow_phase = ~shadow_phase;
    end
  endtask

  task automatic set_mode(input logic want_sci);
    if (shadow_sci != want_sci) begin
      // equals riding along with mode is outranked by mode
      send_press(MODE_PRESS | ($urandom_range(0, 1) ? EQ_PRESS : '0));
    end
  endtask

  // Type an operand digit by digit, most significant first. Mostly random length
  // and value; sometimes one of the wrap edges (32767, 32768, 65535, 99999).
  task automatic send_operand();
    int unsigned v;
    int unsigned p;
    int ndig;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = 32767;
        1:       v = 32768;
        2:       v = 65535;
        default: v = 99999;
      endcase
      ndig = 5;
    end else begin
      v    = $urandom_range(0, 99999);
      ndig = $urandom_range(0, 5);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      p = 1;
      repeat (i) p = p * DEC_BASE;
      send_press(key_press((v / p) % DEC_BASE));
    end
  endtask

  // A well-formed calculation: operand, operator, operand, equals.
  task automatic run_calculation();
    int pick;
    logic [OP_W-1:0] code;
    if (shadow_phase) send_press(EQ_PRESS);  // close whatever was left open
    set_mode(1'b0);
    send_operand();
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      // equals as the operator: latches the equals code
      send_press(EQ_PRESS);
    end else begin
      code = (pick == 1) ? OP_W'($urandom_range(OP_DIV + 1, OP_EQUALS - 1))
                         : OP_W'($urandom_range(OP_ADD, OP_DIV));
      set_mode(1'b1);
      send_press(key_press(code - 1));
      set_mode(1'b0);
    end
    if ($urandom_range(0, 7) == 0) begin
      // operator key during second operand entry is dropped
      set_mode(1'b1);
      send_press(key_press($urandom_range(0, SCI_KEYS - 1)));
      set_mode(1'b0);
    end
    send_operand();
    send_press(EQ_PRESS);
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_buttons_pressed <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    send_press('0);               // nothing pressed
    send_press('1);               // all pressed: digit 0 wins
    // 32768 wraps to the most negative operand
    send_press(bit_of(3));
    send_press(bit_of(2));
    send_press(bit_of(7));
    send_press(bit_of(6));
    send_press(bit_of(8));
    send_press(MODE_PRESS);
    send_press(bit_of(OP_DIV - 1));
    send_press(MODE_PRESS);
    // 65535 wraps to -1: most negative over -1 gives the largest result
    send_press(bit_of(6));
    send_press(bit_of(5));
    send_press(bit_of(5));
    send_press(bit_of(3));
    send_press(bit_of(5));
    send_press(EQ_PRESS);
    send_press(EQ_PRESS);                 // equals in phase 0 latches the equals code
    send_press(MODE_PRESS | EQ_PRESS);    // mode outranks equals, toggles in phase 1
    send_press(bit_of(OP_ADD - 1));       // operator in phase 1 is ignored
    send_press(bit_of(9));                // key 9 stays a digit in scientific mode
    send_press(EQ_PRESS);                 // latched equals evaluates to zero
    send_press(bit_of(SCI_KEYS - 1));     // scientific operator code 9
    send_press(EQ_PRESS);                 // scientific operators give zero
    send_press(bit_of(OP_DIV - 1));       // divide with an empty second operand
    send_press(EQ_PRESS);                 // divide by zero gives zero

    // Random part: mostly full calculations, some loose noise presses.
    while (presses_sent < DIRECTED_PRESSES + RANDOM_PRESSES) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       send_press(BTN_W'($urandom));
            1:       send_press('0);
            default: send_press(bit_of($urandom_range(0, BTN_W - 1)));
          endcase
        end
      end else begin
        run_calculation();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d press words and %0d checked status words,", presses_sent,
             words_checked);
    $display("%0d of them equals evaluations, with two long result-side hold-offs.",
             evaluations);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
